// ===== sv/conv3x3_clamped_stream_macros.svh =====
// assertion macros for the 3x3 convolution stream block
// used by the top level; relies on aclk and aresetn in the including scope
`ifndef CONV3X3_CLAMPED_STREAM_MACROS_SVH
`define CONV3X3_CLAMPED_STREAM_MACROS_SVH

// same-cycle implication, disabled during reset
`define C3S_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("c3s check failed");

// next-cycle implication, disabled during reset
`define C3S_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("c3s check failed");

`endif

// ===== sv/c3s_pkg.sv =====
// shared types, constants and helper functions for the 3x3 convolution stream
// no dependencies
`timescale 1ns / 1ps

package c3s_pkg;

    localparam int MAX_WIDTH_DEF      = 1024;
    localparam int MAX_HEIGHT_DEF     = 4096;
    localparam int COEF_FRAC_BITS_DEF = 12;

    // register indexes on the configuration port
    localparam logic [2:0] REG_KERN_TOP  = 3'd0;
    localparam logic [2:0] REG_KERN_MID  = 3'd1;
    localparam logic [2:0] REG_KERN_BOT  = 3'd2;
    localparam logic [2:0] REG_WIDTH     = 3'd3;
    localparam logic [2:0] REG_HEIGHT    = 3'd4;
    localparam logic [2:0] REG_CHANNELS  = 3'd5;
    localparam logic [2:0] REG_KEEP      = 3'd6;

    typedef logic [23:0]        pix_t;
    typedef logic [8:0][23:0]   taps_t;
    typedef logic [2:0][47:0]   kernel_t;

    typedef struct packed {
        logic [11:0] row;
        logic [9:0]  col;
        logic        last;
    } res_meta_t;

    // clamp a relative window index into [lo, 2]
    function automatic logic [1:0] sel_idx(input logic [2:0] rel, input logic [1:0] lo);
        logic [2:0] x;
        x = (rel < {1'b0, lo}) ? {1'b0, lo} : rel;
        if (x > 3'd2) begin
            x = 3'd2;
        end
        return x[1:0];
    endfunction

    // window slot of row wr, column wc
    function automatic logic [3:0] tap_slot(input logic [1:0] wr, input logic [1:0] wc);
        return ({2'b00, wr} << 1) + {2'b00, wr} + {2'b00, wc};
    endfunction

    // unsigned 8-bit sample times signed 16-bit coefficient
    function automatic logic signed [24:0] mul_px(input logic [7:0] px, input logic [15:0] c);
        logic signed [24:0] a;
        logic signed [24:0] b;
        a = {17'b0, px};
        b = {{9{c[15]}}, c};
        return a * b;
    endfunction

endpackage

// ===== sv/c3s_line_buf.sv =====
// two line memories, one per row parity, with registered reads
// depends on c3s_pkg
`timescale 1ns / 1ps

module c3s_line_buf #(
    parameter int MAX_WIDTH = c3s_pkg::MAX_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [$clog2(MAX_WIDTH)-1:0] addr,
    input  logic                         parity,
    input  c3s_pkg::pix_t                wdata,
    output c3s_pkg::pix_t                cur_data,
    output c3s_pkg::pix_t                prv_data
);
    import c3s_pkg::*;

    pix_t mem0 [MAX_WIDTH];
    pix_t mem1 [MAX_WIDTH];
    pix_t rd0_reg;
    pix_t rd1_reg;
    logic par_reg;

    // read old contents, write the current row's memory
    always_ff @(posedge aclk) begin
        if (en) begin
            rd0_reg <= mem0[addr];
            rd1_reg <= mem1[addr];
            par_reg <= parity;
            if (!parity) begin
                mem0[addr] <= wdata;
            end else begin
                mem1[addr] <= wdata;
            end
        end
    end

    assign cur_data = par_reg ? rd1_reg : rd0_reg;
    assign prv_data = par_reg ? rd0_reg : rd1_reg;

endmodule

// ===== sv/c3s_window.sv =====
// 3x3 window, pending result mask and clamped tap selection
// depends on c3s_pkg
`timescale 1ns / 1ps

module c3s_window #(
    parameter int MAX_WIDTH  = c3s_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = c3s_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  c3s_pkg::pix_t                 in_px,
    input  c3s_pkg::pix_t                 in_cur,
    input  c3s_pkg::pix_t                 in_prv,
    input  logic [$clog2(MAX_HEIGHT)-1:0] in_row,
    input  logic [$clog2(MAX_WIDTH)-1:0]  in_col,
    input  logic                          in_row_end,
    input  logic                          in_last_row,
    output logic                          out_valid,
    input  logic                          out_ready,
    output c3s_pkg::taps_t                out_taps,
    output c3s_pkg::res_meta_t            out_meta
);
    import c3s_pkg::*;

    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int CW = $clog2(MAX_WIDTH);

    pix_t          win_reg [9];
    logic [3:0]    mask_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [1:0]    lo_r_reg;
    logic [1:0]    lo_c_reg;
    taps_t         taps_reg;
    res_meta_t     meta_reg;
    logic          tv_reg;

    logic          emit_fire;
    logic [3:0]    sel;
    logic [3:0]    mask_after;
    logic          load;
    logic [3:0]    new_mask;
    logic          rsel;
    logic          csel;
    taps_t         taps_next;
    res_meta_t     meta_next;
    logic [1:0]    wr [3];
    logic [1:0]    wc [3];

    // pick the earliest pending result
    always_comb begin
        priority if (mask_reg[0]) begin
            sel = 4'b0001;
        end else if (mask_reg[1]) begin
            sel = 4'b0010;
        end else if (mask_reg[2]) begin
            sel = 4'b0100;
        end else begin
            sel = 4'b1000;
        end
    end

    assign emit_fire  = (mask_reg != 4'b0) && (!tv_reg || out_ready);
    assign mask_after = mask_reg & ~sel;
    assign in_ready   = (mask_reg == 4'b0) || (emit_fire && (mask_after == 4'b0));
    assign load       = in_valid && in_ready;

    // results released by the incoming word, in raster order
    assign new_mask[0] = (in_row != '0) && (in_col != '0);
    assign new_mask[1] = (in_row != '0) && in_row_end;
    assign new_mask[2] = in_last_row && (in_col != '0);
    assign new_mask[3] = in_last_row && in_row_end;

    assign rsel = sel[2] | sel[3];
    assign csel = sel[1] | sel[3];

    // clamped tap selection from the window
    always_comb begin
        for (int d = 0; d < 3; d++) begin
            wr[d] = sel_idx(3'({2'b00, rsel}) + 3'(d), lo_r_reg);
            wc[d] = sel_idx(3'({2'b00, csel}) + 3'(d), lo_c_reg);
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                taps_next[r*3+c] = win_reg[tap_slot(wr[r], wc[c])];
            end
        end
        meta_next.row  = 12'(row_reg + RW'(rsel) - RW'(1));
        meta_next.col  = 10'(col_reg + CW'(csel) - CW'(1));
        meta_next.last = (mask_after == 4'b0);
    end

    // window shift and pending mask
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= '0;
            end
            mask_reg <= '0;
        end else begin
            if (load) begin
                for (int r = 0; r < 3; r++) begin
                    win_reg[r*3]   <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2] <= in_cur;
                win_reg[5] <= in_prv;
                win_reg[8] <= in_px;
                mask_reg   <= new_mask;
            end else if (emit_fire) begin
                mask_reg <= mask_after;
            end
        end
    end

    // position of the loaded word and its edge limits
    always_ff @(posedge aclk) begin
        if (load) begin
            row_reg  <= in_row;
            col_reg  <= in_col;
            lo_r_reg <= (in_row == '0) ? 2'd2 : ((in_row == RW'(1)) ? 2'd1 : 2'd0);
            lo_c_reg <= (in_col == '0) ? 2'd2 : ((in_col == CW'(1)) ? 2'd1 : 2'd0);
        end
    end

    // tap output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tv_reg <= 1'b0;
        end else if (emit_fire) begin
            tv_reg <= 1'b1;
        end else if (out_ready) begin
            tv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            taps_reg <= taps_next;
            meta_reg <= meta_next;
        end
    end

    assign out_valid = tv_reg;
    assign out_taps  = taps_reg;
    assign out_meta  = meta_reg;

endmodule

// ===== sv/c3s_mac.sv =====
// products, channel sums and rounding with saturation, three register stages
// depends on c3s_pkg
`timescale 1ns / 1ps

module c3s_mac #(
    parameter int COEF_FRAC_BITS = c3s_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  c3s_pkg::kernel_t   kernel,
    input  logic [1:0]         nch,
    input  logic               keep,
    input  logic               in_valid,
    output logic               in_ready,
    input  c3s_pkg::taps_t     in_taps,
    input  c3s_pkg::res_meta_t in_meta,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_a,
    output logic [7:0]         out_b,
    output logic [7:0]         out_c,
    output c3s_pkg::res_meta_t out_meta
);
    import c3s_pkg::*;

    localparam logic signed [31:0] HALF = 32'sd1 <<< (COEF_FRAC_BITS - 1);

    logic signed [24:0] prod_reg [3][9];
    logic signed [24:0] prod_next [3][9];
    res_meta_t          m1_reg;
    logic               v1_reg;
    logic signed [28:0] sum_reg [3];
    logic signed [28:0] sum_next [3];
    res_meta_t          m2_reg;
    logic               v2_reg;
    logic [7:0]         res_reg [3];
    logic [7:0]         res_next [3];
    res_meta_t          m3_reg;
    logic               v3_reg;
    logic               rdy1;
    logic               rdy2;
    logic               rdy3;

    function automatic logic [7:0] round_sat(input logic signed [31:0] s);
        logic signed [31:0] t;
        logic signed [31:0] q;
        t = s + HALF;
        q = t >>> COEF_FRAC_BITS;
        if (t <= 0) begin
            return 8'd0;
        end else if (q > 32'sd255) begin
            return 8'd255;
        end else begin
            return q[7:0];
        end
    endfunction

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // per tap and channel products, unused channels forced to zero
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int t = 0; t < 9; t++) begin
                if (2'(ch) < nch || (ch == 0)) begin
                    prod_next[ch][t] = mul_px(in_taps[t][8*ch +: 8],
                                              kernel[t/3][16*(t%3) +: 16]);
                end else begin
                    prod_next[ch][t] = '0;
                end
            end
        end
    end

    // nine-tap sums per channel
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum_next[ch] = '0;
            for (int t = 0; t < 9; t++) begin
                sum_next[ch] = sum_next[ch] + 29'(prod_reg[ch][t]);
            end
        end
    end

    // rounding, saturation and channel merge
    always_comb begin
        if (keep) begin
            for (int ch = 0; ch < 3; ch++) begin
                res_next[ch] = round_sat(32'(sum_reg[ch]));
            end
        end else begin
            res_next[0] = round_sat(32'(sum_reg[0]) + 32'(sum_reg[1]) + 32'(sum_reg[2]));
            res_next[1] = 8'd0;
            res_next[2] = 8'd0;
        end
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            prod_reg <= prod_next;
            m1_reg   <= in_meta;
        end
        if (rdy2 && v1_reg) begin
            sum_reg <= sum_next;
            m2_reg  <= m1_reg;
        end
        if (rdy3 && v2_reg) begin
            res_reg <= res_next;
            m3_reg  <= m2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_a     = res_reg[0];
    assign out_b     = res_reg[1];
    assign out_c     = res_reg[2];
    assign out_meta  = m3_reg;

endmodule

// ===== sv/conv3x3_clamped_stream.sv =====
// path: an accepted word passes the input stage with the line memory read, the window
//   and mask, the tap register and the MAC product, sum and result registers
// throughput: one word per cycle unless stalled; a word releasing k results holds the
//   window stage until all k are out (two at a row end, up to four at the frame end)
// reset: counters, window, pipeline valids and registers return to defaults;
//   line memories are not cleared and need no clearing pass
// top level: config port, position counters, input stage; uses c3s_pkg and submodules
`timescale 1ns / 1ps

module conv3x3_clamped_stream #(
    parameter int MAX_WIDTH      = c3s_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT     = c3s_pkg::MAX_HEIGHT_DEF,
    parameter int COEF_FRAC_BITS = c3s_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_sample_a,
    input  logic [7:0]  s_sample_b,
    input  logic [7:0]  s_sample_c,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_result_a,
    output logic [7:0]  m_result_b,
    output logic [7:0]  m_result_c,
    output logic [11:0] m_out_row,
    output logic [9:0]  m_out_col,
    output logic        m_last_of_run
);
    import c3s_pkg::*;
    `include "conv3x3_clamped_stream_macros.svh"

    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int CW = $clog2(MAX_WIDTH);

    logic [47:0]   kern_top_reg;
    logic [47:0]   kern_mid_reg;
    logic [47:0]   kern_bot_reg;
    logic [10:0]   fw_reg;
    logic [12:0]   fh_reg;
    logic [1:0]    cc_reg;
    logic          keep_reg;
    logic [2:0]    cfg_idx;
    logic          cfg_wr;

    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [15:0]   w_eff;
    logic [15:0]   h_eff;
    logic [1:0]    nch_eff;
    logic          row_end;
    logic          last_row;
    logic          accept;

    logic          s1_valid_reg;
    pix_t          s1_px_reg;
    logic [RW-1:0] s1_row_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_row_end_reg;
    logic          s1_last_row_reg;
    pix_t          cur_data;
    pix_t          prv_data;
    pix_t          px_in;

    logic          win_ready;
    logic          tap_valid;
    logic          mac_ready;
    taps_t         taps;
    res_meta_t     tap_meta;
    res_meta_t     res_meta;
    kernel_t       kernel;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kern_top_reg <= '0;
            kern_mid_reg <= 48'h0000_1000_0000;
            kern_bot_reg <= '0;
            fw_reg       <= 11'd1024;
            fh_reg       <= 13'd1024;
            cc_reg       <= 2'd3;
            keep_reg     <= 1'b1;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_KERN_TOP: kern_top_reg <= pwdata[47:0];
                REG_KERN_MID: kern_mid_reg <= pwdata[47:0];
                REG_KERN_BOT: kern_bot_reg <= pwdata[47:0];
                REG_WIDTH:    fw_reg       <= pwdata[10:0];
                REG_HEIGHT:   fh_reg       <= pwdata[12:0];
                REG_CHANNELS: cc_reg       <= pwdata[1:0];
                REG_KEEP:     keep_reg     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_KERN_TOP: prdata = {16'b0, kern_top_reg};
            REG_KERN_MID: prdata = {16'b0, kern_mid_reg};
            REG_KERN_BOT: prdata = {16'b0, kern_bot_reg};
            REG_WIDTH:    prdata = {53'b0, fw_reg};
            REG_HEIGHT:   prdata = {51'b0, fh_reg};
            REG_CHANNELS: prdata = {62'b0, cc_reg};
            REG_KEEP:     prdata = {63'b0, keep_reg};
            default:      prdata = '0;
        endcase
    end

    // effective geometry
    always_comb begin
        if (fw_reg == 11'd0) begin
            w_eff = 16'd1;
        end else if ({5'b0, fw_reg} > 16'(MAX_WIDTH)) begin
            w_eff = 16'(MAX_WIDTH);
        end else begin
            w_eff = {5'b0, fw_reg};
        end
        if (fh_reg == 13'd0) begin
            h_eff = 16'd1;
        end else if ({3'b0, fh_reg} > 16'(MAX_HEIGHT)) begin
            h_eff = 16'(MAX_HEIGHT);
        end else begin
            h_eff = {3'b0, fh_reg};
        end
        nch_eff = (cc_reg == 2'd0) ? 2'd1 : cc_reg;
    end

    assign row_end  = (16'(col_reg) + 16'd1) >= w_eff;
    assign last_row = (16'(row_reg) + 16'd1) >= h_eff;
    assign s_ready  = !s1_valid_reg || win_ready;
    assign accept   = s_valid && s_ready;
    assign px_in    = {s_sample_c, s_sample_b, s_sample_a};

    // raster position of the next word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (accept) begin
            if (row_end) begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + RW'(1);
            end else begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // input stage, aligned with the line memory read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_px_reg       <= px_in;
            s1_row_reg      <= row_reg;
            s1_col_reg      <= col_reg;
            s1_row_end_reg  <= row_end;
            s1_last_row_reg <= last_row;
        end
    end

    c3s_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk     (aclk),
        .en       (accept),
        .addr     (col_reg),
        .parity   (row_reg[0]),
        .wdata    (px_in),
        .cur_data (cur_data),
        .prv_data (prv_data)
    );

    c3s_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s1_valid_reg),
        .in_ready    (win_ready),
        .in_px       (s1_px_reg),
        .in_cur      (cur_data),
        .in_prv      (prv_data),
        .in_row      (s1_row_reg),
        .in_col      (s1_col_reg),
        .in_row_end  (s1_row_end_reg),
        .in_last_row (s1_last_row_reg),
        .out_valid   (tap_valid),
        .out_ready   (mac_ready),
        .out_taps    (taps),
        .out_meta    (tap_meta)
    );

    assign kernel = {kern_bot_reg, kern_mid_reg, kern_top_reg};

    c3s_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .kernel    (kernel),
        .nch       (nch_eff),
        .keep      (keep_reg),
        .in_valid  (tap_valid),
        .in_ready  (mac_ready),
        .in_taps   (taps),
        .in_meta   (tap_meta),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_a     (m_result_a),
        .out_b     (m_result_b),
        .out_c     (m_result_c),
        .out_meta  (res_meta)
    );

    assign m_out_row     = res_meta.row;
    assign m_out_col     = res_meta.col;
    assign m_last_of_run = res_meta.last;

    // checks
    `C3S_ASSERT_NXT(a_col_wrap, accept && row_end, col_reg == '0)
    `C3S_ASSERT_NXT(a_s1_load, accept, s1_valid_reg)
    `C3S_ASSERT_IMP(a_stall_src, !s_ready, s1_valid_reg && !win_ready)

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the 3x3 clamped convolution stream
// depends on c3s_pkg and conv3x3_clamped_stream; holds its own window and line predictor
`timescale 1ns / 1ps

module tb;
    import c3s_pkg::*;

    localparam int LINE_W     = 1024;
    localparam int ROWS_MAX   = 4096;
    localparam int FRAC       = 12;
    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [11:0] row;
        logic [9:0]  col;
        logic        last;
    } pixel_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_sample_a = '0;
    logic [7:0]  s_sample_b = '0;
    logic [7:0]  s_sample_c = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_result_a;
    logic [7:0]  m_result_b;
    logic [7:0]  m_result_c;
    logic [11:0] m_out_row;
    logic [9:0]  m_out_col;
    logic        m_last_of_run;

    conv3x3_clamped_stream dut (.*);

    always #5 aclk = ~aclk;

    // predictor state and configuration copy
    logic [47:0] kern [3];
    logic [10:0] cfg_width;
    logic [12:0] cfg_height;
    logic [1:0]  cfg_chan;
    logic        cfg_keep;
    logic [23:0] line_mem [2*LINE_W];
    logic [23:0] win [9];
    logic [11:0] row_cnt;
    logic [9:0]  col_cnt;

    logic [23:0] pixels_pending [$];
    pixel_out_t  filtered_expected [$];
    int          mismatches = 0;
    int          idle_cycles = 0;

    function automatic int clamp_tap(longint v, longint hi, longint base);
        longint x;
        x = v;
        if (x < 0) x = 0;
        if (x > hi) x = hi;
        x = x - base;
        if (x < 0) x = 0;
        if (x > 2) x = 2;
        return int'(x);
    endfunction

    function automatic logic [7:0] round_clip(longint s);
        longint t;
        t = s + (longint'(1) << (FRAC - 1));
        if (t <= 0) return 8'd0;
        t = t >>> FRAC;
        return (t > 255) ? 8'd255 : t[7:0];
    endfunction

    // filtered value of output pixel (r,c) from the current window
    function automatic pixel_out_t filter_at(longint r, longint c, longint i, longint j,
                                             int nch);
        longint     acc [3];
        pixel_out_t o;
        int         wr;
        int         wc;
        logic [23:0] px;
        logic signed [15:0] k;
        acc = '{0, 0, 0};
        for (int dr = 0; dr < 3; dr++) begin
            wr = clamp_tap(r + dr - 1, i, i - 2);
            for (int dc = 0; dc < 3; dc++) begin
                wc = clamp_tap(c + dc - 1, j, j - 2);
                px = win[wr*3 + wc];
                k = kern[dr][16*dc +: 16];
                for (int ch = 0; ch < 3; ch++)
                    acc[ch] += longint'(px[8*ch +: 8]) * longint'(k);
            end
        end
        for (int ch = nch; ch < 3; ch++) acc[ch] = 0;
        if (cfg_keep) begin
            o.a = round_clip(acc[0]);
            o.b = round_clip(acc[1]);
            o.c = round_clip(acc[2]);
        end else begin
            o.a = round_clip(acc[0] + acc[1] + acc[2]);
            o.b = 8'd0;
            o.c = 8'd0;
        end
        o.row = r[11:0];
        o.col = c[9:0];
        o.last = 1'b0;
        return o;
    endfunction

    // advance the window by one accepted pixel and queue what it releases
    function automatic void push_pixel(logic [23:0] px);
        int         w;
        int         h;
        int         nch;
        int         i;
        int         j;
        int         cur;
        int         prv;
        bit         row_end;
        bit         last_row;
        pixel_out_t outs [$];
        w = (cfg_width == 0) ? 1 : ((cfg_width > LINE_W) ? LINE_W : cfg_width);
        h = (cfg_height == 0) ? 1 : ((cfg_height > ROWS_MAX) ? ROWS_MAX : cfg_height);
        nch = (cfg_chan == 0) ? 1 : cfg_chan;
        i = row_cnt;
        j = (col_cnt >= LINE_W) ? LINE_W - 1 : col_cnt;
        row_end = (j + 1 >= w);
        last_row = (i + 1 >= h);
        cur = (i & 1) * LINE_W + j;
        prv = ((i + 1) & 1) * LINE_W + j;
        for (int r = 0; r < 3; r++) begin
            win[r*3] = win[r*3 + 1];
            win[r*3 + 1] = win[r*3 + 2];
        end
        win[2] = line_mem[cur];
        win[5] = line_mem[prv];
        win[8] = px;
        line_mem[cur] = px;
        if (i >= 1 && j >= 1) outs.push_back(filter_at(i - 1, j - 1, i, j, nch));
        if (i >= 1 && row_end) outs.push_back(filter_at(i - 1, j, i, j, nch));
        if (last_row && j >= 1) outs.push_back(filter_at(i, j - 1, i, j, nch));
        if (last_row && row_end) outs.push_back(filter_at(i, j, i, j, nch));
        if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
        foreach (outs[n]) filtered_expected.push_back(outs[n]);
        if (row_end) begin
            col_cnt = '0;
            row_cnt = last_row ? 12'd0 : 12'(i + 1);
        end else begin
            col_cnt = 10'(j + 1);
        end
    endfunction

    // sender: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) push_pixel({s_sample_c, s_sample_b, s_sample_a});
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pixels_pending.size() > 0) begin
                    {s_sample_c, s_sample_b, s_sample_a} <= pixels_pending.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left = burst_left - 1;
                    end else begin
                        burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                               : $urandom_range(1, 8);
                        gap_left = $urandom_range(0, 4) == 0 ? $urandom_range(5, 20)
                                                             : $urandom_range(0, 3);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern: stall rate changes at random intervals
    int stall_pct = 0;
    int stall_timer = 0;
    always @(posedge aclk) begin
        if (stall_timer == 0) begin
            stall_timer = $urandom_range(50, 300);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
        end else begin
            stall_timer = stall_timer - 1;
        end
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // result checker
    pixel_out_t got;
    pixel_out_t want;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got = '{m_result_a, m_result_b, m_result_c, m_out_row, m_out_col, m_last_of_run};
            if (filtered_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: a=%0d b=%0d c=%0d row=%0d col=%0d last=%0b",
                             got.a, got.b, got.c, got.row, got.col, got.last);
            end else begin
                want = filtered_expected.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("mismatch: exp a=%0d b=%0d c=%0d row=%0d col=%0d last=%0b, ",
                               want.a, want.b, want.c, want.row, want.col, want.last);
                        $display("got a=%0d b=%0d c=%0d row=%0d col=%0d last=%0b",
                                 got.a, got.b, got.c, got.row, got.col, got.last);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either stream and no config access
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_KERN_TOP: kern[0] = value[47:0];
            REG_KERN_MID: kern[1] = value[47:0];
            REG_KERN_BOT: kern[2] = value[47:0];
            REG_WIDTH:    cfg_width = value[10:0];
            REG_HEIGHT:   cfg_height = value[12:0];
            REG_CHANNELS: cfg_chan = value[1:0];
            default:      cfg_keep = value[0];
        endcase
    endtask

    task automatic setup(logic [47:0] kt, logic [47:0] km, logic [47:0] kb,
                         int w, int h, int nch, bit keep);
        write_reg(REG_KERN_TOP, 64'(kt));
        write_reg(REG_KERN_MID, 64'(km));
        write_reg(REG_KERN_BOT, 64'(kb));
        write_reg(REG_WIDTH, 64'(w));
        write_reg(REG_HEIGHT, 64'(h));
        write_reg(REG_CHANNELS, 64'(nch));
        write_reg(REG_KEEP, 64'(keep));
    endtask

    // queue one whole frame and wait for the block to drain
    task automatic run_frame(int n, int mode);
        logic [23:0] px;
        for (int p = 0; p < n; p++) begin
            case (mode)
                1: px = 24'hFFFFFF;
                2: px = (p % 2) ? 24'hFFFFFF : 24'h000000;
                default: px = 24'($urandom);
            endcase
            pixels_pending.push_back(px);
        end
        while (pixels_pending.size() != 0 || s_valid || filtered_expected.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [47:0] rand_kern_row();
        logic [47:0] r;
        if ($urandom_range(0, 3) == 0) return {16'($urandom), 32'($urandom)};
        for (int c = 0; c < 3; c++) r[16*c +: 16] = 16'($urandom_range(0, 2048)) - 16'd700;
        return r;
    endfunction

    int w;
    int h;
    int fed = 0;
    initial begin
        kern = '{48'h0, 48'h0000_1000_0000, 48'h0};
        cfg_width = 11'd1024;
        cfg_height = 13'd1024;
        cfg_chan = 2'd3;
        cfg_keep = 1'b1;
        foreach (line_mem[n]) line_mem[n] = '0;
        foreach (win[n]) win[n] = '0;
        row_cnt = '0;
        col_cnt = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: single pixel frame, identity kernel, full scale
        setup(48'h0, 48'h0000_1000_0000, 48'h0, 1, 1, 3, 1'b1);
        run_frame(1, 1);
        // largest positive coefficients, merged channels saturate high
        setup({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, 3, 3, 3, 1'b0);
        run_frame(9, 2);
        // most negative coefficients clip to zero
        setup({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 3, 2, 2, 1'b1);
        run_frame(6, 1);
        // zero width, height and channel count act as one
        setup(48'h0, 48'h0000_1000_0000, 48'h0, 0, 0, 0, 1'b1);
        run_frame(1, 0);
        // one-column frame
        setup(rand_kern_row(), rand_kern_row(), rand_kern_row(), 1, 4, 1, 1'b0);
        run_frame(4, 0);
        // oversized width acts as the full line; the row is left open so the
        // next geometry takes over mid-frame
        setup(rand_kern_row(), rand_kern_row(), rand_kern_row(), 2047, 1, 3, 1'b1);
        run_frame(30, 0);

        // random frames with random geometry and kernels
        while (fed < 330) begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 6);
            setup(rand_kern_row(), rand_kern_row(), rand_kern_row(), w, h,
                  $urandom_range(0, 3), 1'($urandom_range(0, 1)));
            run_frame(w * h, 0);
            fed += w * h;
        end

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/c3s_pkg.sv
sv/c3s_line_buf.sv
sv/c3s_window.sv
sv/c3s_mac.sv
sv/conv3x3_clamped_stream.sv
tb/sv/tb.sv
